### rtl/core/rtat_pkg.sv
// Shared types and constants for the range table address translator.
`timescale 1ns / 1ps

package rtat_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int ADDR_W              = 64;
    localparam int SLOT_W              = 10;
    localparam int COUNT_REG_W         = 11;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [SLOT_W-1:0]    entry_slot;
        logic [ADDR_W-1:0]    range_base;
        logic [ADDR_W-1:0]    range_length;
        logic [ADDR_W-1:0]    range_target;
        logic [ADDR_W-1:0]    lookup_address;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [ADDR_W-1:0]    translated_address;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    base;
        logic [ADDR_W-1:0]    length;
        logic [ADDR_W-1:0]    target;
    } entry_t;

endpackage

### rtl/core/range_table_address_translator.sv
// Range table address translator: sorted range table with binary-search lookup.
`timescale 1ns / 1ps

// The block keeps a table of TABLE_DEPTH address ranges (source base, length,
// target base) in one synchronous memory with a registered read. A write request
// stores one entry and produces no response; a write to a slot at or above
// TABLE_DEPTH is dropped. A lookup request binary-searches the first
// entries_in_use slots (at most TABLE_DEPTH) and answers with one response: the
// target base plus the offset into the matching range, or hit 0 and address 0.
// Each probe reads the memory in S_READ and compares the address against the
// 65-bit range end in S_EVAL. A hit goes from S_EVAL straight to S_DONE; a miss
// goes to S_DONE when S_READ finds the window empty. A lookup makes at most
// floor(log2(n)) + 1 probes for n searched entries (at most 11 at 1024 entries).
// The next request is taken in the cycle after the response is loaded. The
// memory's single read port and the compare that picks the next probe keep the
// block to one lookup at a time. Input stall is high while a lookup is in flight
// and while its response waits for the output register; a finished response
// waits in the output register while the next request is taken. The table is
// unspecified after reset, so software must write every slot it counts in
// entries_in_use.
module range_table_address_translator #(
    parameter int TABLE_DEPTH = rtat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  rtat_pkg::req_t                     in_data,

    output logic                               out_valid,
    input  logic                               out_stall,
    output rtat_pkg::rsp_t                     out_data,

    input  logic                               cfg_wr_en,
    input  logic [rtat_pkg::COUNT_REG_W-1:0]   cfg_wr_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // take requests
    localparam logic [1:0] S_READ = 2'd1;  // issue probe read or finish on empty window
    localparam logic [1:0] S_EVAL = 2'd2;  // compare probed entry, narrow window
    localparam logic [1:0] S_DONE = 2'd3;  // form response, wait for output slot

    logic [1:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  low_reg, low_next;
    logic [CNT_W-1:0]                  high_reg, high_next;
    logic [IDX_W-1:0]                  mid_reg;
    logic [rtat_pkg::ADDR_W-1:0]       addr_reg;
    logic                              hit_reg, hit_next;
    logic [rtat_pkg::ADDR_W-1:0]       offset_reg;
    logic [rtat_pkg::ADDR_W-1:0]       target_reg;
    logic [rtat_pkg::COUNT_REG_W-1:0]  count_reg;

    logic                              out_valid_reg;
    rtat_pkg::rsp_t                    out_data_reg;

    rtat_pkg::entry_t                  mem [TABLE_DEPTH];
    rtat_pkg::entry_t                  rd_data_reg;

    logic                              in_accept;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    logic [CNT_W-1:0]                  search_count;
    logic [CNT_W-1:0]                  mid_calc;
    logic                              probe_en;
    logic                              out_load;

    logic [rtat_pkg::ADDR_W:0]         range_end;
    logic                              above_start;
    logic                              inside_end;

    // ------------------------------------------------------------------
    // Handshake and table write
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Drop writes aimed past the end of the table.
    assign wr_en   = in_accept && (in_data.req_type == rtat_pkg::REQ_WRITE)
                     && (32'(in_data.entry_slot) < 32'(TABLE_DEPTH));
    assign wr_addr = IDX_W'(32'(in_data.entry_slot));

    // Clamp the searched count to the table depth.
    always_comb
    begin
        if (32'(count_reg) > 32'(TABLE_DEPTH))
            search_count = CNT_W'(TABLE_DEPTH);
        else
            search_count = CNT_W'(32'(count_reg));
    end

    // Lower midpoint of the half-open window [low, high).
    assign mid_calc = low_reg + ((high_reg - CNT_W'(1) - low_reg) >> 1);
    assign probe_en = (state_reg == S_READ) && (low_reg < high_reg);

    // ------------------------------------------------------------------
    // Range compare on the probed entry: end is taken at 65 bits so a range
    // that runs past the top of the address space never wraps.
    // ------------------------------------------------------------------
    assign range_end   = {1'b0, rd_data_reg.base} + {1'b0, rd_data_reg.length};
    assign above_start = (addr_reg >= rd_data_reg.base);
    assign inside_end  = ({1'b0, addr_reg} < range_end);

    // Load the response once the output slot is free or being emptied.
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Search sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_data.req_type == rtat_pkg::REQ_LOOKUP))
                begin
                    low_next   = '0;
                    high_next  = search_count;
                    hit_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (low_reg < high_reg)
                    state_next = S_EVAL;
                else
                    state_next = S_DONE;
            end
            S_EVAL:
            begin
                if (above_start && inside_end)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (!inside_end)
                begin
                    low_next   = CNT_W'(mid_reg) + CNT_W'(1);
                    state_next = S_READ;
                end
                else
                begin
                    high_next  = CNT_W'(mid_reg);
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= '0;
            high_reg  <= '0;
            hit_reg   <= 1'b0;
            count_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            hit_reg   <= hit_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            // Hold the address of the lookup in flight.
            if (in_accept && (in_data.req_type == rtat_pkg::REQ_LOOKUP))
                addr_reg <= in_data.lookup_address;
        end
    end

    // Probe index and hit payload need no reset.
    always_ff @(posedge clk)
    begin
        if (probe_en)
            mid_reg <= mid_calc[IDX_W-1:0];
        if ((state_reg == S_EVAL) && above_start && inside_end)
        begin
            offset_reg <= addr_reg - rd_data_reg.base;
            target_reg <= rd_data_reg.target;
        end
    end

    // ------------------------------------------------------------------
    // Range table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr].base   <= in_data.range_base;
            mem[wr_addr].length <= in_data.range_length;
            mem[wr_addr].target <= in_data.range_target;
        end
    end

    always_ff @(posedge clk)
    begin
        if (probe_en)
            rd_data_reg <= mem[mid_calc[IDX_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.hit                <= hit_reg;
            out_data_reg.translated_address <= hit_reg ? (target_reg + offset_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_resp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("response appeared without a finished lookup");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.translated_address == '0))
        else $error("miss response carries a nonzero address");

    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (CNT_W'(mid_reg) >= low_reg && CNT_W'(mid_reg) < high_reg))
        else $error("probe index outside the search window");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (32'(high_reg) <= 32'(TABLE_DEPTH)))
        else $error("search window exceeds the table");

endmodule

### bench/tb_range_table_address_translator.sv
// Self-checking testbench for the range table address translator.
`timescale 1ns / 1ps

module tb_range_table_address_translator;

    localparam int TABLE_DEPTH    = rtat_pkg::DEFAULT_TABLE_DEPTH;
    localparam int ADDR_W         = rtat_pkg::ADDR_W;
    // Leave margin for a lookup over the full table after the last request.
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int TREE_NODES     = 63;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             in_valid    = 1'b0;
    logic                             in_stall;
    rtat_pkg::req_t                   in_data     = '0;
    logic                             out_valid;
    logic                             out_stall   = 1'b0;
    rtat_pkg::rsp_t                   out_data;
    logic                             cfg_wr_en   = 1'b0;
    logic [rtat_pkg::COUNT_REG_W-1:0] cfg_wr_data = '0;

    range_table_address_translator #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the range table and the entry count register.
    logic [ADDR_W-1:0] src_base [TABLE_DEPTH];
    logic [ADDR_W-1:0] span_len [TABLE_DEPTH];
    logic [ADDR_W-1:0] dst_base [TABLE_DEPTH];
    bit                slot_written [TABLE_DEPTH];
    int unsigned       active_count = 0;

    rtat_pkg::req_t pending_req [$];
    rtat_pkg::rsp_t expected_rsp [$];
    int             phase_slots [$];

    int             send_gap       = 0;
    int             stall_left     = 0;
    int             quiet_cycles   = 0;
    int             mismatch_count = 0;
    bit             calm           = 1'b0;
    bit             ignored_flag;
    rtat_pkg::rsp_t oldest_rsp;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pause length for either side: mostly none or short, now and then long.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Binary search with the same probe order as the block. Flag any probe of a
    // slot that was never written, so that the stimulus can steer clear of it.
    function automatic rtat_pkg::rsp_t translate_lookup(input logic [ADDR_W-1:0] addr,
                                                        output bit blank_read);
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        logic [ADDR_W:0] range_end;
        bit              found;
        bit              past_end;
        rtat_pkg::rsp_t  rsp;
        rsp        = '0;
        found      = 1'b0;
        blank_read = 1'b0;
        lo         = 0;
        hi         = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
        while (lo < hi && !found)
        begin
            mid = lo + (hi - 1 - lo) / 2;
            if (!slot_written[mid])
                blank_read = 1'b1;
            // Compare the end at 65 bits so a range past 2^64 covers the top.
            range_end = {1'b0, src_base[mid]} + {1'b0, span_len[mid]};
            past_end  = ({1'b0, addr} >= range_end);
            if (addr >= src_base[mid] && !past_end)
            begin
                found                  = 1'b1;
                rsp.hit                = 1'b1;
                rsp.translated_address = dst_base[mid] + (addr - src_base[mid]);
            end
            else if (past_end)
                lo = mid + 1;
            else
                hi = mid;
        end
        return rsp;
    endfunction

    function automatic rtat_pkg::req_t make_req(input logic kind, input int slot,
                                                input logic [ADDR_W-1:0] base,
                                                input logic [ADDR_W-1:0] length,
                                                input logic [ADDR_W-1:0] target,
                                                input logic [ADDR_W-1:0] addr);
        rtat_pkg::req_t req;
        req.req_type       = kind;
        req.entry_slot     = slot[rtat_pkg::SLOT_W-1:0];
        req.range_base     = base;
        req.range_length   = length;
        req.range_target   = target;
        req.lookup_address = addr;
        return req;
    endfunction

    function automatic void send_write(input int slot, input logic [ADDR_W-1:0] base,
                                       input logic [ADDR_W-1:0] length,
                                       input logic [ADDR_W-1:0] target);
        pending_req = {pending_req,
                       make_req(rtat_pkg::REQ_WRITE, slot, base, length, target, rand64())};
    endfunction

    // Queue a lookup only if its search touches written slots alone.
    function automatic bit offer_lookup(input logic [ADDR_W-1:0] addr);
        bit             blank_read;
        rtat_pkg::rsp_t unused;
        unused = translate_lookup(addr, blank_read);
        if (blank_read)
            return 1'b0;
        pending_req = {pending_req,
                       make_req(rtat_pkg::REQ_LOOKUP, $urandom_range(0, TABLE_DEPTH - 1),
                                rand64(), rand64(), rand64(), addr)};
        return 1'b1;
    endfunction

    // Hold off until no request is queued, in flight or owed a response.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_count(input int unsigned value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[rtat_pkg::COUNT_REG_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Aim lookups at the edges and the inside of the phase's ranges, plus noise.
    task automatic run_lookups(input int goal);
        int                done;
        int                tries;
        int                s;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] len;
        done  = 0;
        tries = 0;
        while (done < goal && tries < goal * 40)
        begin
            tries++;
            s   = phase_slots[$urandom_range(0, phase_slots.size() - 1)];
            b   = src_base[s];
            len = span_len[s];
            case ($urandom_range(0, 7))
                0:       addr = b;
                1, 2:    addr = (len == 0) ? b : b + rand64() % len;
                3:       addr = b + len - 1;
                4:       addr = b + len;
                5:       addr = b - 1;
                default: addr = rand64();
            endcase
            if (offer_lookup(addr))
                done++;
        end
    endtask

    // Driver: present queued requests, hold while stalled, and insert random gaps.
    // Predict each request at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                active_count = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (in_data.req_type == rtat_pkg::REQ_WRITE)
                begin
                    if (in_data.entry_slot < TABLE_DEPTH)
                    begin
                        src_base[in_data.entry_slot]     = in_data.range_base;
                        span_len[in_data.entry_slot]     = in_data.range_length;
                        dst_base[in_data.entry_slot]     = in_data.range_target;
                        slot_written[in_data.entry_slot] = 1'b1;
                    end
                end
                else
                    expected_rsp = {expected_rsp,
                                    translate_lookup(in_data.lookup_address, ignored_flag)};
            end
            // Advance only when the current request is gone or none is shown.
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_req.size() != 0)
                begin
                    in_data  <= pending_req.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_pause();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted response against the oldest expectation and
    // stall the output at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected response: hit=%0b addr=%h",
                                 out_data.hit, out_data.translated_address);
                end
                else
                begin
                    oldest_rsp = expected_rsp.pop_front();
                    if (out_data.hit !== oldest_rsp.hit ||
                        out_data.translated_address !== oldest_rsp.translated_address)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"response mismatch: expected hit=%0b addr=%h,",
                                      " got hit=%0b addr=%h"},
                                     oldest_rsp.hit, oldest_rsp.translated_address,
                                     out_data.hit, out_data.translated_address);
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_pause();
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int                k;
        int                i;
        int                s;
        int                p;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        int unsigned       tree_lo [$];
        int unsigned       tree_hi [$];
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] lay_base [32];
        logic [ADDR_W-1:0] lay_len [32];
        int unsigned       tree_counts [3];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: every lookup misses.
        program_count(0);
        void'(offer_lookup('0));
        void'(offer_lookup('1));

        // Small sorted table covering translation wrap, a zero result that still
        // hits, an empty range, and a range whose end runs past 2^64.
        send_write(0, 64'h0000_0000_0000_1000, 64'h1000, 64'hFFFF_FFFF_FFFF_F800);
        send_write(1, 64'h0000_0000_0001_0000, 64'h0, 64'h0000_0000_00AB_0000);
        send_write(2, 64'h8000_0000_0000_0000, 64'h10, 64'h0);
        send_write(3, 64'hFFFF_FFFF_FFFF_0000, '1, 64'h0000_0000_1234_0000);
        send_write(TABLE_DEPTH / 2 - 1, 64'h4000_0000_0000_0000, 64'h100, 64'h55);
        program_count(4);
        void'(offer_lookup(64'h0));
        void'(offer_lookup(64'h1000));
        void'(offer_lookup(64'h1C00));
        void'(offer_lookup(64'h1800));
        void'(offer_lookup(64'h1FFF));
        void'(offer_lookup(64'h2000));
        void'(offer_lookup(64'h1_0000));
        void'(offer_lookup(64'h8000_0000_0000_0000));
        void'(offer_lookup(64'h8000_0000_0000_0010));
        void'(offer_lookup(64'hFFFF_FFFF_FFFF_0000));
        void'(offer_lookup('1));

        // Count above the table size: search the full table, first probe hits.
        program_count(2047);
        void'(offer_lookup(64'h4000_0000_0000_0080));

        // Sorted tables of random size and content; the first one holds one entry.
        for (p = 0; p < 7; p++)
        begin
            calm   = ($urandom_range(0, 3) == 0);
            k      = (p == 0) ? 1 : $urandom_range(2, 24);
            cursor = rand64() >> 2;
            for (i = 0; i < k; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       b = cursor;
                    1:       b = cursor + $urandom_range(1, 4096);
                    default: b = cursor + (rand64() >> 24);
                endcase
                case ($urandom_range(0, 7))
                    0:       len = '0;
                    1, 2:    len = rand64() >> 20;
                    default: len = $urandom_range(1, 1 << 20);
                endcase
                if (i == k - 1 && $urandom_range(0, 3) == 0)
                    len = '1;
                lay_base[i] = b;
                lay_len[i]  = len;
                cursor      = b + len;
            end
            phase_slots.delete();
            for (i = 0; i < k; i++)
            begin
                s = ($urandom_range(0, 1) == 0) ? i : k - 1 - i;
                send_write(s, lay_base[s], lay_len[s], rand64());
                phase_slots = {phase_slots, i};
            end
            program_count(($urandom_range(0, 3) == 0) ? $urandom_range(0, k) : k);
            run_lookups($urandom_range(60, 90));
        end

        // Unsorted, overlapping tables: the answer is whatever the probes find.
        for (p = 0; p < 2; p++)
        begin
            calm = 1'b0;
            k    = $urandom_range(4, 16);
            phase_slots.delete();
            for (i = 0; i < k; i++)
            begin
                send_write(i, rand64(), rand64() >> $urandom_range(0, 63), rand64());
                phase_slots = {phase_slots, i};
            end
            program_count(k);
            run_lookups(50);
        end

        // Full-size searches: write the top levels of the search tree over the
        // whole table, each slot in its own stride so the layout stays sorted.
        calm = 1'b0;
        phase_slots.delete();
        tree_lo = {tree_lo, 0};
        tree_hi = {tree_hi, TABLE_DEPTH};
        while (phase_slots.size() < TREE_NODES)
        begin
            lo  = tree_lo.pop_front();
            hi  = tree_hi.pop_front();
            mid = lo + (hi - 1 - lo) / 2;
            phase_slots = {phase_slots, mid};
            if (mid > lo)
            begin
                tree_lo = {tree_lo, lo};
                tree_hi = {tree_hi, mid};
            end
            if (mid + 1 < hi)
            begin
                tree_lo = {tree_lo, mid + 1};
                tree_hi = {tree_hi, hi};
            end
        end
        phase_slots = {phase_slots, TABLE_DEPTH - 1};
        foreach (phase_slots[i])
        begin
            s   = phase_slots[i];
            b   = (64'(s) << 54) | (rand64() >> 14);
            len = rand64() >> 12;
            if (len == 0)
                len = 1;
            if (s == TABLE_DEPTH - 1 && $urandom_range(0, 1) == 0)
                len = '1;
            send_write(s, b, len, rand64());
        end
        tree_counts[0] = TABLE_DEPTH;
        tree_counts[1] = 2047;
        tree_counts[2] = TABLE_DEPTH - 1;
        for (p = 0; p < 3; p++)
        begin
            program_count(tree_counts[p]);
            run_lookups(60);
        end

        wait_drained();
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/core/rtat_pkg.sv
rtl/core/range_table_address_translator.sv
bench/tb_range_table_address_translator.sv
